FILE: rtl/wrms_pkg.sv
// shared constants for the weighted running mean and standard deviation block
`timescale 1ns / 1ps
package wrms_pkg;
    localparam int SAMPLE_W  = 32;
    localparam int WEIGHT_W  = 16;
    localparam int TOTAL_W   = 40;
    localparam int STD_W     = 32;
    localparam int SPREAD_W  = 64;
    localparam int QUO_W     = 64;
    localparam int NUM_W     = 72;
    localparam int CNT_W     = 7;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 104;
    localparam logic [CNT_W-1:0] MEAN_DIV_STEPS = 7'd48;
    localparam logic [CNT_W-1:0] VAR_DIV_STEPS  = 7'd72;
    localparam logic [CNT_W-1:0] SQRT_STEPS     = 7'd32;
endpackage

FILE: rtl/weighted_running_mean_stddev.sv
// weighted running mean and standard deviation, iterative datapath
//
// channel  dir  tdata fields (lsb first)                    tuser
// s_*      in   sample[31:0] weight[47:32]                  clear
// m_*      out  total_weight[39:0] mean_value[71:40]
//               std_dev[103:72]                             no_data
//
// with a nonzero weight a transfer runs a 48 step divide for the mean, four
// passes through one 32x32 multiplier, a 72 step divide for the variance and
// a 32 step square root; zero weight runs only the last two, none if empty
// s_tready is high only while idle; a result still waiting on m_tready holds the
// next one in the done state
// rst_n clears the statistics and the control state at once
`timescale 1ns / 1ps
module weighted_running_mean_stddev
    import wrms_pkg::*;
#(
    parameter int SPREAD_WIDTH = SPREAD_W
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // sample, weight
    input  logic                  s_tuser,   // clear
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // total_weight, mean_value, std_dev
    output logic                  m_tuser    // no_data
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_WD, ST_LOAD_M, ST_DIV_M, ST_MEAN, ST_RESID, ST_MUL_DR,
        ST_MUL_HI, ST_MUL_LO, ST_STEP, ST_ADD, ST_LOAD_V, ST_DIV_V, ST_SQRT, ST_DONE
    } state_t;

    localparam logic [SPREAD_WIDTH:0] SPREAD_MAX = {1'b0, {SPREAD_WIDTH{1'b1}}};
    localparam logic [TOTAL_W:0] TOTAL_MAX = {1'b0, {TOTAL_W{1'b1}}};

    state_t                  state_reg;
    logic [SAMPLE_W-1:0]     x_reg;
    logic [WEIGHT_W-1:0]     w_reg;
    logic [TOTAL_W-1:0]      total_reg;
    logic [SAMPLE_W-1:0]     mean_reg;
    logic [SPREAD_WIDTH-1:0] spread_reg;
    logic                    dneg_reg;
    logic [31:0]             dm_reg;
    logic [31:0]             rm_reg;
    logic [31:0]             plo_reg;
    logic [63:0]             prod_reg;
    logic [63:0]             step_reg;
    logic [TOTAL_W-1:0]      rem_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [QUO_W-1:0]        quo_reg;
    logic                    over_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [63:0]             sv_reg;
    logic [63:0]             sres_reg;
    logic [63:0]             sbit_reg;
    logic [STD_W-1:0]        std_reg;
    logic                    m_tvalid_reg;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;
    logic                    m_tuser_reg;

    logic [SAMPLE_W-1:0]     in_x;
    logic [WEIGHT_W-1:0]     in_w;
    logic [TOTAL_W-1:0]      tot_cur;
    logic [SAMPLE_W-1:0]     mean_cur;
    logic [TOTAL_W:0]        tot_sum;
    logic [SAMPLE_W:0]       d_in;
    logic [SAMPLE_W:0]       d_abs;
    logic [SAMPLE_W:0]       r_val;
    logic [SAMPLE_W:0]       r_abs;
    logic [31:0]             mul_a;
    logic [31:0]             mul_b;
    logic [TOTAL_W:0]        rem_sh;
    logic                    rem_ge;
    logic [64:0]             step_sum;
    logic [SPREAD_WIDTH:0]   spread_sum;
    logic [63:0]             sq_try;
    logic                    sq_ge;

    assign in_x     = s_tdata[SAMPLE_W-1:0];
    assign in_w     = s_tdata[SAMPLE_W+WEIGHT_W-1:SAMPLE_W];
    assign tot_cur  = s_tuser ? '0 : total_reg;
    assign mean_cur = s_tuser ? '0 : mean_reg;
    assign tot_sum  = {1'b0, tot_cur} + {{(TOTAL_W+1-WEIGHT_W){1'b0}}, in_w};
    assign d_in     = {in_x[SAMPLE_W-1], in_x} - {mean_cur[SAMPLE_W-1], mean_cur};
    assign d_abs    = d_in[SAMPLE_W] ? (~d_in + 1'b1) : d_in;
    assign r_val    = {x_reg[SAMPLE_W-1], x_reg} - {mean_reg[SAMPLE_W-1], mean_reg};
    assign r_abs    = r_val[SAMPLE_W] ? (~r_val + 1'b1) : r_val;
    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, total_reg};
    assign step_sum = {1'b0, step_reg} + {33'b0, prod_reg[47:16]};
    assign spread_sum = {1'b0, spread_reg} + {1'b0, step_reg[SPREAD_WIDTH-1:0]};
    assign sq_try   = sres_reg + sbit_reg;
    assign sq_ge    = sv_reg >= sq_try;

    always_comb
    begin
        case (state_reg)
            ST_MUL_WD:
            begin
                mul_a = {{(32-WEIGHT_W){1'b0}}, w_reg};
                mul_b = dm_reg;
            end
            ST_MUL_DR:
            begin
                mul_a = dm_reg;
                mul_b = rm_reg;
            end
            ST_MUL_HI:
            begin
                mul_a = prod_reg[63:32];
                mul_b = {{(32-WEIGHT_W){1'b0}}, w_reg};
            end
            ST_MUL_LO:
            begin
                mul_a = plo_reg;
                mul_b = {{(32-WEIGHT_W){1'b0}}, w_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            total_reg    <= '0;
            mean_reg     <= '0;
            spread_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            prod_reg <= mul_a * mul_b;
            if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        x_reg      <= in_x;
                        w_reg      <= in_w;
                        mean_reg   <= mean_cur;
                        spread_reg <= s_tuser ? '0 : spread_reg;
                        dneg_reg   <= d_in[SAMPLE_W];
                        dm_reg     <= d_abs[31:0];
                        if (in_w != '0)
                        begin
                            total_reg <= (tot_sum > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0]
                                                               : tot_sum[TOTAL_W-1:0];
                            state_reg <= ST_MUL_WD;
                        end
                        else
                        begin
                            total_reg <= tot_cur;
                            std_reg   <= '0;
                            state_reg <= (tot_cur == '0) ? ST_DONE : ST_LOAD_V;
                        end
                    end
                end
                ST_MUL_WD:
                    state_reg <= ST_LOAD_M;
                ST_LOAD_M:
                begin
                    num_reg   <= {prod_reg[47:0], {(NUM_W-48){1'b0}}};
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    over_reg  <= 1'b0;
                    cnt_reg   <= MEAN_DIV_STEPS;
                    state_reg <= ST_DIV_M;
                end
                ST_DIV_M, ST_DIV_V:
                begin
                    num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
                    rem_reg  <= rem_ge ? (rem_sh[TOTAL_W-1:0] - total_reg)
                                       : rem_sh[TOTAL_W-1:0];
                    quo_reg  <= {quo_reg[QUO_W-2:0], rem_ge};
                    over_reg <= over_reg | quo_reg[QUO_W-1];
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == 7'd1)
                        state_reg <= (state_reg == ST_DIV_M) ? ST_MEAN : ST_SQRT;
                    if (cnt_reg == 7'd1 && state_reg == ST_DIV_V)
                    begin
                        sv_reg   <= (over_reg | quo_reg[QUO_W-1]) ? '1
                                    : {quo_reg[QUO_W-2:0], rem_ge};
                        sres_reg <= '0;
                        sbit_reg <= 64'h4000_0000_0000_0000;
                        cnt_reg  <= SQRT_STEPS;
                    end
                end
                ST_MEAN:
                begin
                    mean_reg  <= dneg_reg ? (mean_reg - quo_reg[31:0])
                                          : (mean_reg + quo_reg[31:0]);
                    state_reg <= ST_RESID;
                end
                ST_RESID:
                begin
                    rm_reg    <= r_abs[31:0];
                    state_reg <= ST_MUL_DR;
                end
                ST_MUL_DR:
                    state_reg <= ST_MUL_HI;
                ST_MUL_HI:
                begin
                    plo_reg   <= prod_reg[31:0];
                    state_reg <= ST_MUL_LO;
                end
                ST_MUL_LO:
                begin
                    step_reg  <= {prod_reg[47:0], 16'b0};
                    state_reg <= ST_STEP;
                end
                ST_STEP:
                begin
                    step_reg  <= step_sum[64] ? '1 : step_sum[63:0];
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    if ((SPREAD_WIDTH < 64 && step_reg[63:SPREAD_WIDTH-1] != '0
                         && step_reg > {{(64-SPREAD_WIDTH){1'b0}},
                                        SPREAD_MAX[SPREAD_WIDTH-1:0]})
                        || spread_sum[SPREAD_WIDTH])
                        spread_reg <= SPREAD_MAX[SPREAD_WIDTH-1:0];
                    else
                        spread_reg <= spread_sum[SPREAD_WIDTH-1:0];
                    state_reg <= ST_LOAD_V;
                end
                ST_LOAD_V:
                begin
                    num_reg   <= {{(64-SPREAD_WIDTH){1'b0}}, spread_reg, 8'b0};
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    over_reg  <= 1'b0;
                    cnt_reg   <= VAR_DIV_STEPS;
                    state_reg <= ST_DIV_V;
                end
                ST_SQRT:
                begin
                    if (sq_ge)
                    begin
                        sv_reg   <= sv_reg - sq_try;
                        sres_reg <= {1'b0, sres_reg[63:1]} + sbit_reg;
                    end
                    else
                        sres_reg <= {1'b0, sres_reg[63:1]};
                    sbit_reg <= {2'b0, sbit_reg[63:2]};
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == 7'd1)
                    begin
                        std_reg   <= sq_ge ? (sres_reg[32:1] + sbit_reg[31:0])
                                           : sres_reg[32:1];
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {std_reg, mean_reg, total_reg};
                        m_tuser_reg  <= (total_reg == '0);
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
endmodule
